@@ design/owms_pkg.sv @@
package owms_pkg;

	localparam int unsigned TICK_W      = 10;
	localparam int unsigned BIT_IDX_W   = 3;
	localparam int unsigned BYTE_IDX_W  = 4;
	localparam int unsigned CFG_IDX_W   = 3;

	localparam logic [BYTE_IDX_W-1:0] READ_BYTES = 4'd9;
	localparam logic [BIT_IDX_W-1:0]  LAST_BIT   = 3'd7;

	localparam logic [7:0] CMD_SKIP    = 8'hCC;
	localparam logic [7:0] CMD_CONVERT = 8'h44;
	localparam logic [7:0] CMD_READ    = 8'hBE;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_CONVERT = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_W1_REL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_W0_LOW     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_W0_REL     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_R_SAMPLE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_R_RECOVER  = 3'd7;

	typedef struct packed {
		logic [TICK_W-1:0] reset_low;
		logic [TICK_W-1:0] reset_wait;
		logic [TICK_W-1:0] short_low;
		logic [TICK_W-1:0] w1_release;
		logic [TICK_W-1:0] w0_low;
		logic [TICK_W-1:0] w0_release;
		logic [TICK_W-1:0] r_sample;
		logic [TICK_W-1:0] r_recover;
	} timing_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic       byte_last;
	} res_t;

endpackage

@@ design/owms_cfg.sv @@
module owms_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [owms_pkg::CFG_IDX_W-1:0] index,
	input  logic [owms_pkg::TICK_W-1:0]    data,
	output owms_pkg::timing_t        timing
);
	import owms_pkg::*;

	timing_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.reset_low  <= 10'd480;
			regs_q.reset_wait <= 10'd480;
			regs_q.short_low  <= 10'd6;
			regs_q.w1_release <= 10'd64;
			regs_q.w0_low     <= 10'd60;
			regs_q.w0_release <= 10'd10;
			regs_q.r_sample   <= 10'd9;
			regs_q.r_recover  <= 10'd55;
		end else if (wr_en) begin
			case (index)
				REG_RESET_LOW:  regs_q.reset_low  <= data;
				REG_RESET_WAIT: regs_q.reset_wait <= data;
				REG_SHORT_LOW:  regs_q.short_low  <= data;
				REG_W1_REL:     regs_q.w1_release <= data;
				REG_W0_LOW:     regs_q.w0_low     <= data;
				REG_W0_REL:     regs_q.w0_release <= data;
				REG_R_SAMPLE:   regs_q.r_sample   <= data;
				REG_R_RECOVER:  regs_q.r_recover  <= data;
				default: ;
			endcase
		end
	end

	assign timing = regs_q;

endmodule

@@ design/owms_core.sv @@
module owms_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        req_type,
	input  logic              bus_level,
	input  owms_pkg::timing_t timing,
	output owms_pkg::res_t    res
);
	import owms_pkg::*;

	typedef enum logic [9:0] {
		PH_IDLE     = 10'b00_0000_0001,
		PH_RST_LOW  = 10'b00_0000_0010,
		PH_RST_WAIT = 10'b00_0000_0100,
		PH_W1_LOW   = 10'b00_0000_1000,
		PH_W1_REL   = 10'b00_0001_0000,
		PH_W0_LOW   = 10'b00_0010_0000,
		PH_W0_REL   = 10'b00_0100_0000,
		PH_R_LOW    = 10'b00_1000_0000,
		PH_R_WAIT   = 10'b01_0000_0000,
		PH_R_REC    = 10'b10_0000_0000
	} phase_t;

	phase_t                phase_q, ph, ph_n;
	logic [TICK_W-1:0]     tick_q, tc, tc1, tick_n, limit, dur;
	logic [BIT_IDX_W-1:0]  bit_q, bi, bit_n;
	logic [BYTE_IDX_W-1:0] byte_q, byi, byte_n, byi_inc;
	logic [7:0]            shift_q, sb, shift_n, sb_in;
	logic                  rd_q, rd, start, done;

	// bit of the command stream for a given byte and bit position
	function automatic logic cmd_bit(logic [BYTE_IDX_W-1:0] b, logic r,
			logic [BIT_IDX_W-1:0] i);
		logic [7:0] c;
		begin
			c = (b == '0) ? CMD_SKIP : (r ? CMD_READ : CMD_CONVERT);
			cmd_bit = c[i];
		end
	endfunction

	always_comb begin
		start = (phase_q == PH_IDLE) && ((req_type == REQ_CONVERT) || (req_type == REQ_READ));
		ph    = start ? PH_RST_LOW : phase_q;
		tc    = start ? '0 : tick_q;
		bi    = start ? '0 : bit_q;
		byi   = start ? '0 : byte_q;
		sb    = start ? '0 : shift_q;
		rd    = start ? (req_type == REQ_READ) : rd_q;

		res = '0;
		res.busy_res = (ph != PH_IDLE);

		case (ph)
			PH_RST_LOW:  begin res.drive_low = 1'b1; limit = timing.reset_low; end
			PH_RST_WAIT: limit = timing.reset_wait;
			PH_W1_LOW:   begin res.drive_low = 1'b1; limit = timing.short_low; end
			PH_W1_REL:   limit = timing.w1_release;
			PH_W0_LOW:   begin res.drive_low = 1'b1; limit = timing.w0_low; end
			PH_W0_REL:   limit = timing.w0_release;
			PH_R_LOW:    begin res.drive_low = 1'b1; limit = timing.short_low; end
			PH_R_WAIT:   limit = timing.r_sample;
			PH_R_REC:    limit = timing.r_recover;
			default:     limit = TICK_W'(1);
		endcase

		dur     = (limit == '0) ? TICK_W'(1) : limit;
		tc1     = tc + TICK_W'(1);
		done    = (tc1 >= dur);
		byi_inc = byi + BYTE_IDX_W'(1);
		sb_in   = {bus_level, sb[7:1]};

		ph_n    = ph;
		tick_n  = done ? '0 : tc1;
		bit_n   = bi;
		byte_n  = byi;
		shift_n = sb;

		if (ph == PH_IDLE) begin
			tick_n = tc;
		end else if (done) begin
			case (ph)
				PH_RST_LOW:  ph_n = PH_RST_WAIT;
				PH_RST_WAIT: ph_n = cmd_bit(byi, rd, bi) ? PH_W1_LOW : PH_W0_LOW;
				PH_W1_LOW:   ph_n = PH_W1_REL;
				PH_W0_LOW:   ph_n = PH_W0_REL;
				PH_W1_REL, PH_W0_REL: begin
					if (bi == LAST_BIT) begin
						bit_n = '0;
						if (byi != '0) begin
							byte_n  = '0;
							shift_n = '0;
							ph_n    = rd ? PH_R_LOW : PH_IDLE;
						end else begin
							byte_n = byi_inc;
							ph_n   = cmd_bit(byi_inc, rd, '0) ? PH_W1_LOW : PH_W0_LOW;
						end
					end else begin
						bit_n = bi + BIT_IDX_W'(1);
						ph_n  = cmd_bit(byi, rd, bi + BIT_IDX_W'(1)) ? PH_W1_LOW : PH_W0_LOW;
					end
				end
				PH_R_LOW:    ph_n = PH_R_WAIT;
				PH_R_WAIT: begin
					if (bi == LAST_BIT) begin
						res.byte_valid = 1'b1;
						res.byte_value = sb_in;
						res.byte_last  = (byi_inc >= READ_BYTES) || (byi_inc == '0);
						bit_n   = '0;
						byte_n  = byi_inc;
						shift_n = '0;
					end else begin
						bit_n   = bi + BIT_IDX_W'(1);
						shift_n = sb_in;
					end
					ph_n = PH_R_REC;
				end
				PH_R_REC:    ph_n = (byi >= READ_BYTES) ? PH_IDLE : PH_R_LOW;
				default:     ph_n = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			shift_q <= '0;
			rd_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= ph_n;
			tick_q  <= tick_n;
			bit_q   <= bit_n;
			byte_q  <= byte_n;
			shift_q <= shift_n;
			rd_q    <= rd;
		end
	end

endmodule

@@ design/owms_skid.sv @@
module owms_skid (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  owms_pkg::res_t in_res,
	output logic           out_valid,
	input  logic           out_ready,
	output owms_pkg::res_t out_res
);
	import owms_pkg::*;

	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : in_res;
		end else if (in_valid && !skid_valid_q) begin
			skid_q <= in_res;
		end
	end

endmodule

@@ design/one_wire_master_sequencer.sv @@
// Bus master for a single-wire sensor line, stepped by one tick transaction
// per microsecond on the slave stream.
//  s_tuser : request kind (0 plain tick, 1 start conversion, 2 read scratchpad)
//  s_tdata : bit 0 is the line level sampled during this tick
//  m_tdata : per-tick result: line drive, busy flag, scratchpad byte
//  m_tuser : high when a scratchpad byte completes on this tick
//  m_tlast : high on the final scratchpad byte
// A request seen while idle starts a transaction on that very tick: reset
// pulse, release, skip-ROM byte, command byte, then (for a read) nine bytes
// read slot by slot. Requests arriving while busy are ignored.
// Throughput is one tick per clock while s_tready is high; each result is
// registered when its tick is accepted and leaves from the output register.
// The sequencer state advances only on accepted ticks, so time on the line is
// counted in transactions, not in clocks. When m_tready is low the output
// register holds and one more tick lands in the skid register; s_tready then
// drops until the consumer drains it. Reset clears the sequencer to idle,
// empties both buffers and restores the default slot timings. The user writes
// timing registers through cfg_* only when idle; the block does not enforce it.
module one_wire_master_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] bus_level, [7:1] zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] drive_low, [1] busy_res, [9:2] byte_value, [15:10] zero
	output logic        m_tuser,   // [0] byte_valid
	output logic        m_tlast,   // byte_last
	input  logic        cfg_wr_en,
	input  logic [owms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [owms_pkg::TICK_W-1:0]    cfg_data
);
	import owms_pkg::*;

	timing_t timing;
	res_t    step_res, out_res;
	logic    accept;

	assign accept = s_tvalid && s_tready;

	owms_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.timing (timing)
	);

	// next-state and per-tick result, straight from the accepted tick
	owms_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req_type  (s_tuser),
		.bus_level (s_tdata[0]),
		.timing    (timing),
		.res       (step_res)
	);

	// output register plus one-deep skid
	owms_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_ready  (s_tready),
		.in_res    (step_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {6'd0, out_res.byte_value, out_res.busy_res, out_res.drive_low};
	assign m_tuser = out_res.byte_valid;
	assign m_tlast = out_res.byte_last;

	// a completed byte only ever comes from inside a transaction
	a_byte_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[1])
		else $error("byte completed outside a transaction");

	// the line is only pulled low while busy
	a_drive_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[1])
		else $error("line driven while idle");

	// last flag only rides on a completed byte
	a_last_with_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("byte_last without byte_valid");

	// back-pressure upstream only follows a stalled output
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("s_tready dropped without an output stall");

endmodule

@@ tb/testbench.sv @@
module testbench;
	import owms_pkg::*;

	// Request code with no meaning; the sequencer must treat it as a plain tick
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// Cycles with no transaction on any port before the run is abandoned
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// Length of the one long consumer hold-off that fills the skid buffer
	localparam int unsigned PRESSURE_HOLD = 100;

	// Sequencer phases, as tracked by the line predictor
	typedef enum logic [3:0] {
		S_IDLE, S_RST_LOW, S_RST_WAIT, S_W1_LOW, S_W1_REL,
		S_W0_LOW, S_W0_REL, S_R_LOW, S_R_WAIT, S_R_REC
	} seq_phase_t;

	// One tick as offered on the slave stream
	typedef struct packed {
		logic [1:0] req;
		logic       lvl;
	} tick_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [15:0]          m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0]    cfg_data = '0;

	one_wire_master_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // [0] bus_level, [7:1] zero
		.s_tuser   (s_tuser),   // [1:0] req_type
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // [0] drive_low, [1] busy_res, [9:2] byte_value, [15:10] zero
		.m_tuser   (m_tuser),   // [0] byte_valid
		.m_tlast   (m_tlast),   // byte_last
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Ticks waiting for the driver, and line results owed by the block, in order
	tick_t tick_q[$];
	res_t  line_q[$];

	// Line predictor state, kept apart from the block's own
	seq_phase_t        ln_phase = S_IDLE;
	logic [TICK_W-1:0] ln_ticks = '0;
	logic [2:0]        ln_bit = '0;
	logic [3:0]        ln_byte = '0;
	logic [7:0]        ln_shift = '0;
	logic              ln_read = 1'b0;
	timing_t           ln_tim;

	// Flow control knobs and tallies
	logic        allow_idle = 1'b1;
	int unsigned n_errors = 0;
	int unsigned n_results = 0;
	int unsigned n_ticks = 0;
	int unsigned n_settings = 0;
	int unsigned n_convs = 0;
	int unsigned n_reads = 0;
	int unsigned n_bytes = 0;

	// A programmed duration of zero behaves as one tick
	function automatic logic [TICK_W-1:0] span(input logic [TICK_W-1:0] v);
		return (v == '0) ? 10'd1 : v;
	endfunction

	// Write slot kind for the current command bit, LSB first
	function automatic seq_phase_t slot_for_bit();
		logic [7:0] cmd;
		if (ln_byte == '0)
			cmd = CMD_SKIP;
		else if (ln_read)
			cmd = CMD_READ;
		else
			cmd = CMD_CONVERT;
		return cmd[ln_bit] ? S_W1_LOW : S_W0_LOW;
	endfunction

	// Advances the predictor by one tick and returns what the line should show
	function automatic res_t predict_tick(input logic [1:0] req, input logic lvl);
		res_t              r;
		logic [TICK_W-1:0] lim;
		r = '0;
		lim = 10'd1;
		// a request only counts while idle; the tick that carries it is the
		// first tick of the reset pulse
		if (ln_phase == S_IDLE && (req == REQ_CONVERT || req == REQ_READ)) begin
			ln_read = (req == REQ_READ);
			ln_phase = S_RST_LOW;
			ln_ticks = '0;
			ln_bit = '0;
			ln_byte = '0;
			ln_shift = '0;
			if (ln_read)
				n_reads++;
			else
				n_convs++;
		end
		if (ln_phase != S_IDLE) begin
			r.busy_res = 1'b1;
			case (ln_phase)
				S_RST_LOW: begin
					r.drive_low = 1'b1;
					lim = ln_tim.reset_low;
				end
				S_RST_WAIT: lim = ln_tim.reset_wait;
				S_W1_LOW: begin
					r.drive_low = 1'b1;
					lim = ln_tim.short_low;
				end
				S_W1_REL: lim = ln_tim.w1_release;
				S_W0_LOW: begin
					r.drive_low = 1'b1;
					lim = ln_tim.w0_low;
				end
				S_W0_REL: lim = ln_tim.w0_release;
				S_R_LOW: begin
					r.drive_low = 1'b1;
					lim = ln_tim.short_low;
				end
				S_R_WAIT: lim = ln_tim.r_sample;
				S_R_REC: lim = ln_tim.r_recover;
				default: ;
			endcase
			ln_ticks = ln_ticks + 1'b1;
			if (ln_ticks >= span(lim)) begin
				ln_ticks = '0;
				case (ln_phase)
					S_RST_LOW: ln_phase = S_RST_WAIT;
					S_RST_WAIT: ln_phase = slot_for_bit();
					S_W1_LOW: ln_phase = S_W1_REL;
					S_W0_LOW: ln_phase = S_W0_REL;
					S_W1_REL, S_W0_REL: begin
						// end of a write slot: next bit, next byte, reads or done
						if (ln_bit == LAST_BIT) begin
							ln_bit = '0;
							if (ln_byte != '0) begin
								ln_byte = '0;
								ln_shift = '0;
								ln_phase = ln_read ? S_R_LOW : S_IDLE;
							end else begin
								ln_byte = ln_byte + 1'b1;
								ln_phase = slot_for_bit();
							end
						end else begin
							ln_bit = ln_bit + 1'b1;
							ln_phase = slot_for_bit();
						end
					end
					S_R_LOW: ln_phase = S_R_WAIT;
					S_R_WAIT: begin
						// sample on the last released tick, shifting in from the top
						ln_shift = {lvl, ln_shift[7:1]};
						if (ln_bit == LAST_BIT) begin
							r.byte_valid = 1'b1;
							r.byte_value = ln_shift;
							r.byte_last = ({1'b0, ln_byte} + 5'd1) >= {1'b0, READ_BYTES};
							ln_bit = '0;
							ln_byte = ln_byte + 1'b1;
							ln_shift = '0;
							n_bytes++;
						end else begin
							ln_bit = ln_bit + 1'b1;
						end
						ln_phase = S_R_REC;
					end
					S_R_REC: ln_phase = (ln_byte >= READ_BYTES) ? S_IDLE : S_R_LOW;
					default: ln_phase = S_IDLE;
				endcase
			end
		end
		return r;
	endfunction

	function automatic void queue_tick(input logic [1:0] req, input logic lvl);
		tick_t t;
		t.req = req;
		t.lvl = lvl;
		line_q.push_back(predict_tick(req, lvl));
		tick_q.push_back(t);
		n_ticks++;
	endfunction

	// Runs the current bus sequence out; requests seen while busy are ignored
	function automatic void finish_sequence();
		while (ln_phase != S_IDLE)
			queue_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
	endfunction

	// Mostly well-formed requests when idle, with noise requests while busy
	function automatic void run_random(input int unsigned n);
		int unsigned w;
		logic [1:0]  req;
		for (int unsigned i = 0; i < n; i++) begin
			if (ln_phase == S_IDLE) begin
				w = $urandom_range(0, 9);
				req = (w < 4) ? REQ_READ : (w < 6) ? REQ_CONVERT :
					(w == 6) ? REQ_UNUSED : REQ_TICK;
			end else begin
				w = $urandom_range(0, 19);
				req = (w == 0) ? REQ_READ : (w == 1) ? REQ_CONVERT :
					(w == 2) ? REQ_UNUSED : REQ_TICK;
			end
			queue_tick(req, 1'($urandom_range(0, 1)));
		end
		finish_sequence();
	endfunction

	function automatic timing_t pick_timing(input int unsigned lo, input int unsigned hi);
		timing_t t;
		t.reset_low  = 10'($urandom_range(hi, lo));
		t.reset_wait = 10'($urandom_range(hi, lo));
		t.short_low  = 10'($urandom_range(hi, lo));
		t.w1_release = 10'($urandom_range(hi, lo));
		t.w0_low     = 10'($urandom_range(hi, lo));
		t.w0_release = 10'($urandom_range(hi, lo));
		t.r_sample   = 10'($urandom_range(hi, lo));
		t.r_recover  = 10'($urandom_range(hi, lo));
		return t;
	endfunction

	// Waits for every tick to be taken and every result to come back
	task automatic drain();
		while (tick_q.size() != 0 || line_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	// Only called with the block idle; the predictor takes the same values
	task automatic write_timing(input timing_t t);
		put_reg(REG_RESET_LOW, t.reset_low);
		put_reg(REG_RESET_WAIT, t.reset_wait);
		put_reg(REG_SHORT_LOW, t.short_low);
		put_reg(REG_W1_REL, t.w1_release);
		put_reg(REG_W0_LOW, t.w0_low);
		put_reg(REG_W0_REL, t.w0_release);
		put_reg(REG_R_SAMPLE, t.r_sample);
		put_reg(REG_R_RECOVER, t.r_recover);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		ln_tim = t;
		n_settings++;
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch on result %0d: %s is %h, expected %h", n_results, what, got, want);
		n_errors++;
	endtask

	// Slave-side driver: random gap bursts, otherwise back-to-back ticks
	int unsigned drv_gap;
	tick_t       drv_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			drv_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (drv_gap > 0) begin
				drv_gap--;
				s_tvalid <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 15) == 0) begin
				drv_gap = $urandom_range(0, 11);
				s_tvalid <= 1'b0;
			end else if (tick_q.size() != 0) begin
				drv_item = tick_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drv_item.req;
				s_tdata <= {7'd0, drv_item.lvl};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Master-side monitor: checks each result transaction and paces m_tready
	int unsigned mon_stall;
	int unsigned mon_hold;
	logic        pressure_done;
	res_t        want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			mon_stall = 0;
			mon_hold = 0;
			pressure_done = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (line_q.size() == 0) begin
					report_mismatch("unexpected result", 8'd1, 8'd0);
				end else begin
					want = line_q.pop_front();
					if (m_tdata[0] !== want.drive_low)
						report_mismatch("drive_low", 8'(m_tdata[0]), 8'(want.drive_low));
					if (m_tdata[1] !== want.busy_res)
						report_mismatch("busy_res", 8'(m_tdata[1]), 8'(want.busy_res));
					if (m_tdata[9:2] !== want.byte_value)
						report_mismatch("byte_value", m_tdata[9:2], want.byte_value);
					if (m_tdata[15:10] !== 6'd0)
						report_mismatch("tdata padding", 8'(m_tdata[15:10]), 8'd0);
					if (m_tuser !== want.byte_valid)
						report_mismatch("byte_valid", 8'(m_tuser), 8'(want.byte_valid));
					if (m_tlast !== want.byte_last)
						report_mismatch("byte_last", 8'(m_tlast), 8'(want.byte_last));
				end
			end
			// one long hold-off while plenty is queued, so input backs up
			if (!pressure_done && tick_q.size() > 150) begin
				pressure_done = 1'b1;
				mon_hold = PRESSURE_HOLD;
			end
			if (mon_hold > 0) begin
				mon_hold--;
				m_tready <= 1'b0;
			end else if (mon_stall > 0) begin
				mon_stall--;
				m_tready <= 1'b0;
			end else if (allow_idle && $urandom_range(0, 15) == 0) begin
				mon_stall = $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: too long with no transaction anywhere means the block is stuck
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", quiet_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	timing_t tim;

	initial begin
		ln_tim = '{reset_low: 10'd480, reset_wait: 10'd480, short_low: 10'd6,
			w1_release: 10'd64, w0_low: 10'd60, w0_release: 10'd10,
			r_sample: 10'd9, r_recover: 10'd55};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// all durations zero, which must behave as one tick each
		write_timing('0);
		queue_tick(REQ_TICK, 1'b0);
		queue_tick(REQ_TICK, 1'b1);
		queue_tick(REQ_UNUSED, 1'b0);
		queue_tick(REQ_UNUSED, 1'b1);
		queue_tick(REQ_CONVERT, 1'b0);
		queue_tick(REQ_READ, 1'b1);
		queue_tick(REQ_CONVERT, 1'b1);
		queue_tick(REQ_UNUSED, 1'b0);
		finish_sequence();
		// scratchpad read with the line high for early bytes, low for the rest
		queue_tick(REQ_READ, 1'b1);
		while (ln_phase != S_IDLE)
			queue_tick(REQ_TICK, ln_byte < 4'd4);
		// new request on the very tick after the previous sequence ends
		queue_tick(REQ_CONVERT, 1'b1);
		finish_sequence();
		drain();

		tim = '{default: 10'd1};
		write_timing(tim);
		run_random(120);
		drain();

		// short random slots, one conversion, no idling
		allow_idle = 1'b0;
		write_timing(pick_timing(0, 3));
		queue_tick(REQ_CONVERT, 1'b0);
		finish_sequence();
		drain();

		// longer random slots, one conversion with noise requests
		allow_idle = 1'b1;
		write_timing(pick_timing(0, 12));
		queue_tick(REQ_CONVERT, 1'b1);
		finish_sequence();
		drain();

		// closing stretch runs flat out on both sides
		allow_idle = 1'b0;
		write_timing(pick_timing(0, 2));
		queue_tick(REQ_READ, 1'b0);
		finish_sequence();
		drain();
		repeat (8) @(posedge clk);

		$display("Stepped %0d ticks under %0d timing settings, durations 0 to 12.",
			n_ticks, n_settings);
		$display("Sequences run: %0d conversions, %0d scratchpad reads, %0d bytes read back.",
			n_convs, n_reads, n_bytes);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
design/owms_pkg.sv
design/owms_cfg.sv
design/owms_core.sv
design/owms_skid.sv
design/one_wire_master_sequencer.sv
tb/testbench.sv
